@@ rtl/core/pps_drift_tracker_top_macros.svh @@
// Assertion helpers for the drift tracker; every check samples on clock
// and is switched off while reset is high.
`ifndef PPS_DRIFT_TRACKER_TOP_MACROS_SVH
`define PPS_DRIFT_TRACKER_TOP_MACROS_SVH

// Same-cycle implication
`define PDT_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication
`define PDT_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ rtl/core/pdt_pkg.sv @@
`timescale 1ns / 1ps

package pdt_pkg;

   // Lock counter defaults
   localparam int LOCK_MAX_DEF   = 5;
   localparam int LOCK_LEVEL_DEF = 3;

   // Field widths
   localparam int TIME_W  = 64;
   localparam int ERR_W   = 24;
   localparam int ACC_W   = 40;
   localparam int FRAC_W  = 16;
   localparam int ALPHA_W = 17;
   localparam int THR_W   = 16;
   localparam int CFG_W   = 32;
   localparam int LVL_OUT_W = 3;

   // Register reset values
   localparam logic [CFG_W-1:0]   EXPECTED_RST = 32'd1000000;
   localparam logic [THR_W-1:0]   THRESHOLD_RST = 16'd5;
   localparam logic [CFG_W-1:0]   TIMEOUT_RST = 32'd3000000;
   localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd13107;

   // Saturation limits
   localparam logic signed [ERR_W-1:0] ERR_MAX = 24'sh7FFFFF;
   localparam logic signed [ERR_W-1:0] ERR_MIN = 24'sh800000;
   localparam logic signed [ACC_W-1:0] ACC_MAX = 40'sh7FFFFFFFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 40'sh8000000000;

   // Request opcodes
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_EXPECTED_INTERVAL = 2'd0,
      CSR_LOCK_THRESHOLD    = 2'd1,
      CSR_TIMEOUT           = 2'd2,
      CSR_ALPHA             = 2'd3
   } csr_index_type;

   // Request after the edge stage
   typedef struct packed {
      logic                    opcode;
      logic [TIME_W-1:0]       time_us;
      logic signed [ERR_W-1:0] err;
      logic                    err_valid;
      logic                    near;
   } item_type;

endpackage

@@ rtl/core/pdt_edge_stage.sv @@
`timescale 1ns / 1ps

module pdt_edge_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_opcode,
   input  logic [pdt_pkg::TIME_W-1:0]         req_time_us,
   input  logic [pdt_pkg::CFG_W-1:0]          expected_interval_us,
   input  logic [pdt_pkg::THR_W-1:0]          lock_threshold_ppm,
   output logic                               item_valid,
   output pdt_pkg::item_type                  item,
   input  logic                               item_take
);

   logic [pdt_pkg::TIME_W-1:0] edge_time_ff, edge_time_in;
   logic                       have_edge_ff, have_edge_in;
   logic                       item_valid_ff, item_valid_in;
   pdt_pkg::item_type          item_ff, item_in;

   logic                              accept;
   logic                              is_edge;
   logic                              err_valid;
   logic [pdt_pkg::TIME_W-1:0]        interval;
   logic [pdt_pkg::TIME_W:0]          diff;
   logic signed [pdt_pkg::ERR_W-1:0]  err;
   logic [pdt_pkg::ERR_W-1:0]         mag;

   assign req_ready  = !item_valid_ff || item_take;
   assign item_valid = item_valid_ff;
   assign item       = item_ff;

   // Interval error against the nominal spacing, saturated to 24 bits
   always_comb begin
      accept    = req_valid && req_ready;
      is_edge   = (req_opcode == pdt_pkg::OP_EDGE);
      err_valid = is_edge && have_edge_ff;
      interval  = req_time_us - edge_time_ff;
      diff      = {1'b0, interval} - {33'b0, expected_interval_us};
      if (!diff[pdt_pkg::TIME_W]) begin
         err = (|diff[63:23]) ? pdt_pkg::ERR_MAX : $signed(diff[23:0]);
      end else begin
         err = (&diff[64:23]) ? $signed(diff[23:0]) : pdt_pkg::ERR_MIN;
      end
      if (!err_valid) begin
         err = '0;
      end
      mag = err[23] ? (~err + 24'd1) : err;
   end

   // Track the last edge and load the stage register
   always_comb begin
      edge_time_in  = edge_time_ff;
      have_edge_in  = have_edge_ff;
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      if (item_take) begin
         item_valid_in = 1'b0;
      end
      if (accept) begin
         item_valid_in     = 1'b1;
         item_in.opcode    = req_opcode;
         item_in.time_us   = req_time_us;
         item_in.err       = err;
         item_in.err_valid = err_valid;
         item_in.near      = (mag < {8'b0, lock_threshold_ppm});
         if (is_edge) begin
            edge_time_in = req_time_us;
            have_edge_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_edge_ff  <= 1'b0;
         item_valid_ff <= 1'b0;
      end else begin
         have_edge_ff  <= have_edge_in;
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_time_ff <= edge_time_in;
      item_ff      <= item_in;
   end

endmodule

@@ rtl/core/pdt_filter_stage.sv @@
`timescale 1ns / 1ps

module pdt_filter_stage #(
   parameter int LOCK_MAX   = pdt_pkg::LOCK_MAX_DEF,
   parameter int LOCK_LEVEL = pdt_pkg::LOCK_LEVEL_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_valid,
   input  pdt_pkg::item_type                     item,
   output logic                                  item_take,
   input  logic [pdt_pkg::CFG_W-1:0]             timeout_us,
   input  logic [pdt_pkg::ALPHA_W-1:0]           alpha_q16,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pdt_pkg::ACC_W-1:0]      rsp_correction_q16,
   output logic                                  rsp_locked,
   output logic [pdt_pkg::LVL_OUT_W-1:0]         rsp_lock_level,
   output logic signed [pdt_pkg::ERR_W-1:0]      rsp_edge_error_ppm,
   output logic                                  rsp_error_valid
);

   localparam int CNT_W = $clog2(LOCK_MAX + 1);
   localparam int CMP_W = CNT_W + 4;
   localparam int EXT_W = CNT_W + pdt_pkg::LVL_OUT_W;

   logic signed [pdt_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [pdt_pkg::TIME_W-1:0]        last_upd_ff, last_upd_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [pdt_pkg::ACC_W-1:0]  rsp_corr_ff;
   logic                              rsp_locked_ff, rsp_locked_in;
   logic [pdt_pkg::LVL_OUT_W-1:0]     rsp_level_ff, rsp_level_in;
   logic signed [pdt_pkg::ERR_W-1:0]  rsp_err_ff;
   logic                              rsp_err_valid_ff;

   logic signed [24:0]                sh;
   logic signed [17:0]                alpha_s;
   logic signed [42:0]                p_hi;
   logic [32:0]                       p_lo;
   logic signed [43:0]                delta;
   logic signed [43:0]                acc_diff;
   logic signed [pdt_pkg::ACC_W-1:0]  acc_sat;
   logic [pdt_pkg::TIME_W-1:0]        since;
   logic                              expired;
   logic [EXT_W-1:0]                  cnt_ext;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_ready);

   // IIR step: acc - floor(alpha * (acc + err*2^16) / 2^16), split at the Q16 point
   always_comb begin
      sh       = {acc_ff[39], acc_ff[39:16]} + {item.err[23], item.err};
      alpha_s  = {1'b0, alpha_q16};
      p_hi     = alpha_s * sh;
      p_lo     = {16'b0, alpha_q16} * {17'b0, acc_ff[15:0]};
      delta    = {p_hi[42], p_hi} + {27'b0, p_lo[32:16]};
      acc_diff = {{4{acc_ff[39]}}, acc_ff} - delta;
      if (acc_diff[43:39] == 5'b00000 || acc_diff[43:39] == 5'b11111) begin
         acc_sat = acc_diff[39:0];
      end else begin
         acc_sat = acc_diff[43] ? pdt_pkg::ACC_MIN : pdt_pkg::ACC_MAX;
      end
      since   = item.time_us - last_upd_ff;
      expired = (since > {32'b0, timeout_us});
   end

   // Update filter, lock counter and timeout state
   always_comb begin
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      last_upd_in = last_upd_ff;
      if (item_take) begin
         if (item.opcode == pdt_pkg::OP_EDGE) begin
            if (item.err_valid) begin
               acc_in      = acc_sat;
               last_upd_in = item.time_us;
               if (item.near) begin
                  if (cnt_ff < CNT_W'(LOCK_MAX)) begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end else if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end else if (expired) begin
            acc_in = '0;
            cnt_in = '0;
         end
      end
      cnt_ext       = EXT_W'(cnt_in);
      rsp_level_in  = cnt_ext[pdt_pkg::LVL_OUT_W-1:0];
      rsp_locked_in = ({4'b0, cnt_in} >= CMP_W'(LOCK_LEVEL));
      rsp_valid_in  = item_take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         last_upd_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         last_upd_ff  <= last_upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_corr_ff      <= acc_in;
         rsp_locked_ff    <= rsp_locked_in;
         rsp_level_ff     <= rsp_level_in;
         rsp_err_ff       <= item.err;
         rsp_err_valid_ff <= item.err_valid;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_correction_q16 = rsp_corr_ff;
   assign rsp_locked         = rsp_locked_ff;
   assign rsp_lock_level     = rsp_level_ff;
   assign rsp_edge_error_ppm = rsp_err_ff;
   assign rsp_error_valid    = rsp_err_valid_ff;

endmodule

@@ rtl/core/pps_drift_tracker_top.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/ready    | req_opcode, req_time_us
// rsp     | out       | rsp_valid/ready    | correction, lock state, edge error
// csr     | in        | csr_wr_en          | csr_addr, csr_wdata (no read-back)
//
// One request per cycle sustained while rsp_ready stays high; each result passes
// the edge stage register, then the filter and result registers, before it is
// offered and can be taken.
// The correction, lock counter and last-update time each loop on their own
// register in the filter stage; the correction path runs through multipliers.
// Reset is synchronous, active high; state and settings reset, data regs do not.
// A stalled rsp holds its result; one more request parks in the edge stage,
// then req_ready drops.

module pps_drift_tracker_top #(
   parameter int LOCK_MAX   = pdt_pkg::LOCK_MAX_DEF,
   parameter int LOCK_LEVEL = pdt_pkg::LOCK_LEVEL_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_opcode,
   input  logic [pdt_pkg::TIME_W-1:0]            req_time_us,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pdt_pkg::ACC_W-1:0]      rsp_correction_q16,
   output logic                                  rsp_locked,
   output logic [pdt_pkg::LVL_OUT_W-1:0]         rsp_lock_level,
   output logic signed [pdt_pkg::ERR_W-1:0]      rsp_edge_error_ppm,
   output logic                                  rsp_error_valid,
   input  logic                                  csr_wr_en,
   input  logic [1:0]                            csr_addr,
   input  logic [pdt_pkg::CFG_W-1:0]             csr_wdata
);

   logic [pdt_pkg::CFG_W-1:0]   expected_ff, expected_in;
   logic [pdt_pkg::THR_W-1:0]   threshold_ff, threshold_in;
   logic [pdt_pkg::CFG_W-1:0]   timeout_ff, timeout_in;
   logic [pdt_pkg::ALPHA_W-1:0] alpha_ff, alpha_in;

   logic              item_valid;
   logic              item_take;
   pdt_pkg::item_type item;

   // Decode register writes
   always_comb begin
      expected_in  = expected_ff;
      threshold_in = threshold_ff;
      timeout_in   = timeout_ff;
      alpha_in     = alpha_ff;
      if (csr_wr_en) begin
         case (pdt_pkg::csr_index_type'(csr_addr))
            pdt_pkg::CSR_EXPECTED_INTERVAL: expected_in  = csr_wdata;
            pdt_pkg::CSR_LOCK_THRESHOLD:    threshold_in = csr_wdata[pdt_pkg::THR_W-1:0];
            pdt_pkg::CSR_TIMEOUT:           timeout_in   = csr_wdata;
            pdt_pkg::CSR_ALPHA:             alpha_in     = csr_wdata[pdt_pkg::ALPHA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff  <= pdt_pkg::EXPECTED_RST;
         threshold_ff <= pdt_pkg::THRESHOLD_RST;
         timeout_ff   <= pdt_pkg::TIMEOUT_RST;
         alpha_ff     <= pdt_pkg::ALPHA_RST;
      end else begin
         expected_ff  <= expected_in;
         threshold_ff <= threshold_in;
         timeout_ff   <= timeout_in;
         alpha_ff     <= alpha_in;
      end
   end

   pdt_edge_stage u_edge (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_time_us          (req_time_us),
      .expected_interval_us (expected_ff),
      .lock_threshold_ppm   (threshold_ff),
      .item_valid           (item_valid),
      .item                 (item),
      .item_take            (item_take)
   );

   pdt_filter_stage #(
      .LOCK_MAX   (LOCK_MAX),
      .LOCK_LEVEL (LOCK_LEVEL)
   ) u_filter (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (item_valid),
      .item               (item),
      .item_take          (item_take),
      .timeout_us         (timeout_ff),
      .alpha_q16          (alpha_ff),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_correction_q16 (rsp_correction_q16),
      .rsp_locked         (rsp_locked),
      .rsp_lock_level     (rsp_lock_level),
      .rsp_edge_error_ppm (rsp_edge_error_ppm),
      .rsp_error_valid    (rsp_error_valid)
   );

`include "pps_drift_tracker_top_macros.svh"

   // Lock flag follows the counter it reports
   `PDT_ASSERT_NOW(a_lock_flag, rsp_valid,
                   rsp_locked == (int'(rsp_lock_level) >= LOCK_LEVEL),
                   "lock flag disagrees with lock level")
   // No error value leaks out on ticks or the first edge
   `PDT_ASSERT_NOW(a_err_zero, rsp_valid && !rsp_error_valid,
                   rsp_edge_error_ppm == '0,
                   "error nonzero without a measured interval")
   // A taken result with nothing behind it leaves the output empty
   `PDT_ASSERT_NEXT(a_rsp_drain, rsp_valid && rsp_ready && !item_valid,
                    !rsp_valid,
                    "result repeated after it was taken")

endmodule

@@ tb/pps_drift_tracker_top_test.sv @@
`timescale 1ns / 1ps

module pps_drift_tracker_top_test;

   import pdt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_REQUESTS = 70;
   localparam longint ERR_HI = ERR_MAX;
   localparam longint ERR_LO = ERR_MIN;
   localparam longint ACC_HI = ACC_MAX;
   localparam longint ACC_LO = ACC_MIN;

   typedef struct packed {
      logic signed [ACC_W-1:0] correction;
      logic                    locked;
      logic [LVL_OUT_W-1:0]    level;
      logic signed [ERR_W-1:0] edge_err;
      logic                    err_valid;
   } drift_status_type;

   localparam drift_status_type STATUS_CLEAR = '0;

   typedef enum logic [1:0] {
      ROW_TYPED,
      ROW_PREDICTED,
      ROW_WRITE
   } row_kind_type;

   typedef struct {
      row_kind_type     kind;
      logic             op;
      logic [63:0]      at_us;
      csr_index_type    csr_sel;
      logic [31:0]      wdata;
      drift_status_type want;
   } script_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_opcode;
   logic [TIME_W-1:0]       req_time_us;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [ACC_W-1:0] rsp_correction_q16;
   logic                    rsp_locked;
   logic [LVL_OUT_W-1:0]    rsp_lock_level;
   logic signed [ERR_W-1:0] rsp_edge_error_ppm;
   logic                    rsp_error_valid;
   logic                    csr_wr_en;
   csr_index_type           csr_addr;
   logic [CFG_W-1:0]        csr_wdata;

   // Tracker copy: settings and state as the block should hold them
   logic [63:0]             cfg_expected;
   longint                  cfg_threshold;
   logic [63:0]             cfg_timeout;
   longint                  cfg_alpha;
   logic [63:0]             trk_prev_edge;
   bit                      trk_have_edge;
   logic [63:0]             trk_last_update;
   logic signed [ACC_W-1:0] trk_corr;
   int                      trk_level;
   bit                      trk_locked;

   drift_status_type pending_status[$];
   script_row_type   script[$];
   int               mismatch_count = 0;
   int               sent_count = 0;
   int               accepted_results = 0;
   int               cycle_count = 0;

   pps_drift_tracker_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_time_us        (req_time_us),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_correction_q16 (rsp_correction_q16),
      .rsp_locked         (rsp_locked),
      .rsp_lock_level     (rsp_lock_level),
      .rsp_edge_error_ppm (rsp_edge_error_ppm),
      .rsp_error_valid    (rsp_error_valid),
      .csr_wr_en          (csr_wr_en),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata)
   );

   always #10 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ns: timed out with %0d results outstanding", $time,
                  pending_status.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Advance the tracker copy by one request and return the status it reports
   function automatic drift_status_type track_request(input logic op, input logic [63:0] t);
      drift_status_type status;
      logic [63:0]      interval;
      logic [63:0]      gap;
      longint           err;
      longint           sum;
      longint           prod;
      longint           next_corr;
      longint           mag;
      status = STATUS_CLEAR;
      err = 0;
      if (op == OP_EDGE) begin
         if (trk_have_edge) begin
            // interval error, clamped to the 24-bit range
            interval = t - trk_prev_edge;
            if (interval >= cfg_expected) begin
               gap = interval - cfg_expected;
               err = (gap > ERR_HI) ? ERR_HI : longint'(gap);
            end else begin
               gap = cfg_expected - interval;
               err = (gap > -ERR_LO) ? ERR_LO : -longint'(gap);
            end
            // first-order filter, floor of the Q16 product
            sum = longint'(trk_corr) + err * 65536;
            prod = cfg_alpha * sum;
            next_corr = longint'(trk_corr) - (prod >>> FRAC_W);
            if (next_corr > ACC_HI) next_corr = ACC_HI;
            if (next_corr < ACC_LO) next_corr = ACC_LO;
            trk_corr = next_corr[ACC_W-1:0];
            trk_last_update = t;
            // step the lock counter
            mag = (err < 0) ? -err : err;
            if (mag < cfg_threshold) begin
               if (trk_level < LOCK_MAX_DEF) trk_level++;
            end else if (trk_level > 0) begin
               trk_level--;
            end
            trk_locked = (trk_level >= LOCK_LEVEL_DEF);
            status.err_valid = 1'b1;
         end
         trk_prev_edge = t;
         trk_have_edge = 1'b1;
      end else if (t - trk_last_update > cfg_timeout) begin
         trk_corr = '0;
         trk_level = 0;
         trk_locked = 1'b0;
      end
      status.correction = trk_corr;
      status.locked = trk_locked;
      status.level = trk_level[LVL_OUT_W-1:0];
      status.edge_err = err[ERR_W-1:0];
      return status;
   endfunction

   function automatic script_row_type request_row(input logic op, input logic [63:0] t);
      script_row_type row;
      row.kind = ROW_PREDICTED;
      row.op = op;
      row.at_us = t;
      row.csr_sel = CSR_EXPECTED_INTERVAL;
      row.wdata = '0;
      row.want = STATUS_CLEAR;
      return row;
   endfunction

   function automatic script_row_type typed_row(input logic op, input logic [63:0] t,
                                                input drift_status_type want);
      script_row_type row;
      row = request_row(op, t);
      row.kind = ROW_TYPED;
      row.want = want;
      return row;
   endfunction

   function automatic script_row_type csr_row(input csr_index_type sel,
                                              input logic [31:0] data);
      script_row_type row;
      row = request_row(OP_EDGE, '0);
      row.kind = ROW_WRITE;
      row.csr_sel = sel;
      row.wdata = data;
      return row;
   endfunction

   function automatic void check_field(input string field, input longint want,
                                       input longint got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Write one register while the block is idle
   task automatic write_csr(input csr_index_type sel, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_addr <= sel;
      csr_wdata <= data;
      @(posedge clock);
      case (sel)
         CSR_EXPECTED_INTERVAL: cfg_expected = {32'd0, data};
         CSR_LOCK_THRESHOLD:    cfg_threshold = data[THR_W-1:0];
         CSR_TIMEOUT:           cfg_timeout = {32'd0, data};
         CSR_ALPHA:             cfg_alpha = data[ALPHA_W-1:0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one request, hold it until accepted, then record what it should return
   task automatic offer_request(input logic op, input logic [63:0] t, input bit typed,
                                input drift_status_type want);
      drift_status_type status;
      while (!(sent_count >= 300 && sent_count < 400) && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_time_us <= t;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      sent_count++;
      status = track_request(op, t);
      pending_status.push_back(typed ? want : status);
   endtask

   // Drop valid and let every outstanding result come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      // the last result is taken at the edge after its check
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: random back-pressure, one long hold, one calm stretch
   initial begin : result_side
      int               hold_left;
      bit               held_once;
      drift_status_type want;
      hold_left = 0;
      held_once = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!held_once && accepted_results == 200) begin
            held_once = 1'b1;
            hold_left = 150;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (accepted_results >= 300 && accepted_results < 400) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 24);
         end
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            accepted_results++;
            if (pending_status.size() == 0) begin
               $display("%0t ns: result arrived with no request outstanding", $time);
               mismatch_count++;
            end else begin
               want = pending_status.pop_front();
               check_field("correction_q16", want.correction, rsp_correction_q16);
               check_field("locked", want.locked, rsp_locked);
               check_field("lock_level", want.level, rsp_lock_level);
               check_field("edge_error_ppm", want.edge_err, rsp_edge_error_ppm);
               check_field("error_valid", want.err_valid, rsp_error_valid);
            end
         end
      end
   end

   initial begin : request_side
      drift_status_type counted_once;
      logic [63:0]      edge_at;
      logic [63:0]      t;
      logic [31:0]      setting;
      longint           span;
      longint           jitter;
      int               roll;
      bit               busy;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_EDGE;
      req_time_us = '0;
      csr_wr_en = 1'b0;
      csr_addr = CSR_EXPECTED_INTERVAL;
      csr_wdata = '0;
      cfg_expected = {32'd0, EXPECTED_RST};
      cfg_threshold = THRESHOLD_RST;
      cfg_timeout = {32'd0, TIMEOUT_RST};
      cfg_alpha = ALPHA_RST;
      trk_prev_edge = '0;
      trk_have_edge = 1'b0;
      trk_last_update = '0;
      trk_corr = '0;
      trk_level = 0;
      trk_locked = 1'b0;
      counted_once = STATUS_CLEAR;
      counted_once.level = 3'd1;
      counted_once.err_valid = 1'b1;

      // Defaults: idle tick, first edge, lock climb to the top and back
      script.push_back(typed_row(OP_TICK, 64'd0, STATUS_CLEAR));
      script.push_back(typed_row(OP_EDGE, 64'd0, STATUS_CLEAR));
      script.push_back(typed_row(OP_EDGE, 64'd1000000, counted_once));
      script.push_back(request_row(OP_EDGE, 64'd2000004));
      script.push_back(request_row(OP_EDGE, 64'd3000000));
      script.push_back(request_row(OP_EDGE, 64'd4000000));
      script.push_back(request_row(OP_EDGE, 64'd5000000));
      script.push_back(request_row(OP_EDGE, 64'd6000000));
      // error equal to the threshold does not count toward lock
      script.push_back(request_row(OP_EDGE, 64'd7000005));
      // tick exactly at the timeout keeps state, one past clears it
      script.push_back(request_row(OP_TICK, 64'd10000005));
      script.push_back(typed_row(OP_TICK, 64'd10000006, STATUS_CLEAR));
      // huge interval and a backward step both clamp high
      script.push_back(request_row(OP_EDGE, 64'd1099521627782));
      script.push_back(request_row(OP_EDGE, 64'd1099521627781));
      // widest interval and threshold, zero timeout, unity weight
      script.push_back(csr_row(CSR_EXPECTED_INTERVAL, 32'hFFFF_FFFF));
      script.push_back(csr_row(CSR_LOCK_THRESHOLD, 32'hABCD_FFFF));
      script.push_back(csr_row(CSR_TIMEOUT, 32'd0));
      script.push_back(csr_row(CSR_ALPHA, 32'hFFFF_0000));
      script.push_back(request_row(OP_EDGE, 64'hFFFF_FFFF_FFFF_FFFF));
      // time wraps to zero: short interval clamps low
      script.push_back(request_row(OP_EDGE, 64'd0));
      script.push_back(request_row(OP_EDGE, 64'd4286578687));
      script.push_back(request_row(OP_EDGE, 64'd8573157373));
      script.push_back(request_row(OP_TICK, 64'd8573157373));
      script.push_back(typed_row(OP_TICK, 64'd8573157374, STATUS_CLEAR));
      // zero interval, zero threshold, longest timeout, largest weight
      script.push_back(csr_row(CSR_EXPECTED_INTERVAL, 32'd0));
      script.push_back(csr_row(CSR_LOCK_THRESHOLD, 32'hFFFF_0000));
      script.push_back(csr_row(CSR_TIMEOUT, 32'hFFFF_FFFF));
      script.push_back(csr_row(CSR_ALPHA, 32'h0001_FFFF));
      script.push_back(request_row(OP_EDGE, 64'd5));
      script.push_back(request_row(OP_EDGE, 64'd8));
      script.push_back(request_row(OP_EDGE, 64'd8));
      script.push_back(typed_row(OP_TICK, 64'hFFFF_FFFF_FFFF_FFFF, STATUS_CLEAR));
      script.push_back(csr_row(CSR_ALPHA, 32'd0));
      script.push_back(request_row(OP_EDGE, 64'd1000));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      busy = 1'b0;
      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            if (busy) wait_drained();
            busy = 1'b0;
            write_csr(script[i].csr_sel, script[i].wdata);
         end else begin
            busy = 1'b1;
            offer_request(script[i].op, script[i].at_us, script[i].kind == ROW_TYPED,
                          script[i].want);
         end
      end

      // Random phases, each under a fresh register setting
      edge_at = trk_prev_edge;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         case ($urandom_range(4))
            0: setting = EXPECTED_RST;
            1: setting = $urandom_range(1, 2000);
            2: setting = $urandom();
            3: setting = 32'hFFFF_FFFF;
            default: setting = 32'd1;
         endcase
         write_csr(CSR_EXPECTED_INTERVAL, setting);
         case ($urandom_range(4))
            0: setting = THRESHOLD_RST;
            1: setting = $urandom_range(0, 100);
            2: setting = $urandom_range(0, 65535);
            3: setting = 32'd65535;
            default: setting = 32'd0;
         endcase
         write_csr(CSR_LOCK_THRESHOLD, {16'($urandom()), setting[15:0]});
         case ($urandom_range(4))
            0: setting = TIMEOUT_RST;
            1: setting = $urandom();
            2: setting = 32'd0;
            3: setting = 32'hFFFF_FFFF;
            default: setting = $urandom_range(1000, 5000000);
         endcase
         write_csr(CSR_TIMEOUT, setting);
         case ($urandom_range(4))
            0: setting = ALPHA_RST;
            1: setting = $urandom_range(0, 65536);
            2: setting = 32'd65536;
            3: setting = 32'h1FFFF;
            default: setting = 32'd0;
         endcase
         write_csr(CSR_ALPHA, {15'($urandom()), setting[16:0]});

         repeat (PHASE_REQUESTS) begin
            roll = $urandom_range(99);
            if (roll < 64) begin
               // regular edge: nominal spacing plus jitter near the threshold
               span = ($urandom_range(3) != 0) ? cfg_threshold : 2 * cfg_threshold + 3;
               jitter = longint'($urandom_range(0, int'(2 * span))) - span;
               edge_at = edge_at + cfg_expected + jitter;
               offer_request(OP_EDGE, edge_at, 1'b0, STATUS_CLEAR);
            end else if (roll < 82) begin
               // tick around the timeout boundary
               case ($urandom_range(3))
                  0: t = trk_last_update + cfg_timeout;
                  1: t = trk_last_update + cfg_timeout + 1;
                  2: t = trk_last_update + $urandom_range(0, 1000);
                  default: t = trk_last_update + $urandom();
               endcase
               offer_request(OP_TICK, t, 1'b0, STATUS_CLEAR);
            end else if (roll < 92) begin
               // broken sequence: missed pulses or a jump in time
               if ($urandom_range(1) != 0) edge_at = edge_at + $urandom();
               else edge_at = {$urandom(), $urandom()};
               offer_request(OP_EDGE, edge_at, 1'b0, STATUS_CLEAR);
            end else begin
               offer_request(OP_TICK, {$urandom(), $urandom()}, 1'b0, STATUS_CLEAR);
            end
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
